/* rtl/core/frep_pkg.sv */
// Package for the flash range erase planner.
// Holds request and result types, erase action codes and size constants.
// No dependencies.
package frep_pkg;

    // Address and size widths
    localparam int ADDR_BITS     = 24;
    localparam int STATE_W       = ADDR_BITS + 1;
    localparam int BLOCK64_BYTES = 65536;
    localparam int BLOCK32_BYTES = 32768;
    localparam int B64_LOG2      = $clog2(BLOCK64_BYTES);
    localparam int B32_LOG2      = $clog2(BLOCK32_BYTES);
    localparam int SIZE_W        = B64_LOG2 + 1;
    localparam int LG_W          = 4;
    localparam logic [LG_W-1:0] SECTOR_LG_MIN   = 4'd8;
    localparam logic [LG_W-1:0] SECTOR_LG_RESET = 4'd12;

    // Result action codes
    typedef enum logic [2:0] {
        ACT_SECTOR = 3'd0,
        ACT_B32    = 3'd1,
        ACT_B64    = 3'd2,
        ACT_DONE   = 3'd3,
        ACT_FAIL   = 3'd4,
        ACT_REJECT = 3'd5
    } action_t;

    // Request kinds
    localparam logic KIND_RANGE    = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [ADDR_BITS-1:0] start_addr;
        logic [ADDR_BITS-1:0] end_addr;
        logic                 erase_ok;
    } req_t;

    typedef struct packed {
        action_t              action;
        logic [ADDR_BITS-1:0] erase_addr;
    } rsp_t;

    // Status of the walk seen by the top level
    typedef struct packed {
        logic busy;
        logic issued;
    } walk_status_t;

endpackage

/* rtl/core/flash_range_erase_planner.sv */
// Top level of the flash range erase planner: input register, walk, result register.
// Depends on frep_pkg and frep_walk.
//
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  req      | req_valid/req_stall  | req_t: kind, start_addr, end_addr, ok
//  rsp      | rsp_valid/rsp_stall  | rsp_t: action, erase_addr
//  cfg      | cfg_we               | cfg_wdata: sector_size_log2
//
// One request per cycle sustained while rsp_stall is low. A request taken into the input
// register is processed by the walk, which loads its result into the result register.
// Reset clears both register valids and the walk, and sets the sector size to 4K.
// rsp_stall holds the result register; req_stall rises only when the input
// register is full and the result register is held.
module flash_range_erase_planner
    import frep_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  req_t            req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rsp_t            rsp,
    input  logic            cfg_we,
    input  logic [LG_W-1:0] cfg_wdata
);

    logic            s1_valid_reg;
    logic            s1_valid_next;
    req_t            s1_item_reg;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;
    rsp_t            rsp_reg;
    logic [LG_W-1:0] sector_lg_reg;

    logic            advance;
    logic            accept;
    logic            fire;
    rsp_t            walk_rsp;
    walk_status_t    walk_stat;

    // Handshake control
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign fire      = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        if (advance)
            rsp_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
            sector_lg_reg <= SECTOR_LG_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
                sector_lg_reg <= cfg_wdata;
        end
    end

    // Capture the request and the result
    always_ff @(posedge clk)
    begin
        if (accept)
            s1_item_reg <= req;
        if (fire)
            rsp_reg <= walk_rsp;
    end

    frep_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (s1_item_reg),
        .sector_lg (sector_lg_reg),
        .result    (walk_rsp),
        .status    (walk_stat)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef NO_ASSERTIONS
    // A held input request stays in place
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("input register changed while held");

    // Done or failed ends the walk
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (walk_rsp.action == ACT_DONE || walk_rsp.action == ACT_FAIL)
        |=> !walk_stat.busy)
        else $error("walk still busy after done or failure");

    // An issued erase leaves the walk busy
    a_issue_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && walk_stat.issued |=> walk_stat.busy)
        else $error("walk idle after issuing an erase");

    // Input is stalled only with both registers full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> s1_valid_reg && rsp_valid_reg)
        else $error("request stalled with a free register");
`endif

endmodule

/* rtl/core/frep_choose.sv */
// Erase size chooser: picks 64K, 32K or sector erase at an address.
// Gives the erase base and the address just past the erase.
// Depends on frep_pkg.
module frep_choose
    import frep_pkg::*;
(
    input  logic [STATE_W-1:0] addr,
    input  logic [STATE_W-1:0] len,
    input  logic [LG_W-1:0]    sector_lg,
    output action_t            act,
    output logic [STATE_W-1:0] base,
    output logic [STATE_W-1:0] next_addr
);

    logic [LG_W-1:0]    lg_eff;
    logic [SIZE_W-1:0]  sec;
    logic [SIZE_W-1:0]  sec_mask;
    logic [STATE_W-1:0] thr64;
    logic [STATE_W-1:0] thr32;
    logic [SIZE_W-1:0]  step;

    // Saturate the sector size and build its mask
    assign lg_eff   = (sector_lg < SECTOR_LG_MIN) ? SECTOR_LG_MIN : sector_lg;
    assign sec      = SIZE_W'(1) << lg_eff;
    assign sec_mask = sec - SIZE_W'(1);
    assign thr64    = STATE_W'(BLOCK64_BYTES) - {{(STATE_W-SIZE_W){1'b0}}, sec};
    assign thr32    = STATE_W'(BLOCK32_BYTES) - {{(STATE_W-SIZE_W){1'b0}}, sec};

    // Pick the largest erase that fits at this address
    always_comb
    begin
        if (addr[B64_LOG2-1:0] == '0 && len > thr64)
        begin
            act  = ACT_B64;
            base = addr;
            step = SIZE_W'(BLOCK64_BYTES);
        end
        else if (addr[B32_LOG2-1:0] == '0 && len > thr32)
        begin
            act  = ACT_B32;
            base = addr;
            step = SIZE_W'(BLOCK32_BYTES);
        end
        else
        begin
            act  = ACT_SECTOR;
            base = addr & ~{{(STATE_W-SIZE_W){1'b0}}, sec_mask};
            step = sec - (addr[SIZE_W-1:0] & sec_mask);
        end
    end

    assign next_addr = addr + {{(STATE_W-SIZE_W){1'b0}}, step};

endmodule

/* rtl/core/frep_walk.sv */
// Walk state and result logic of the erase planner.
// Holds busy, next address and remaining length; forms one result per request.
// Depends on frep_pkg and frep_choose.
module frep_walk
    import frep_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  req_t            item,
    input  logic [LG_W-1:0] sector_lg,
    output rsp_t            result,
    output walk_status_t    status
);

    logic               busy_reg;
    logic               busy_next;
    logic [STATE_W-1:0] addr_reg;
    logic [STATE_W-1:0] addr_next;
    logic [STATE_W-1:0] len_reg;
    logic [STATE_W-1:0] len_next;

    action_t            cur_act;
    logic [STATE_W-1:0] cur_base;
    logic [STATE_W-1:0] cur_end;
    logic [STATE_W-1:0] cur_step;
    logic [STATE_W-1:0] adv_len;

    logic [STATE_W-1:0] new_start;
    logic [STATE_W-1:0] new_len;
    logic               range_bad;

    logic [STATE_W-1:0] pick_addr;
    logic [STATE_W-1:0] pick_len;
    action_t            pick_act;
    logic [STATE_W-1:0] pick_base;
    logic [STATE_W-1:0] pick_end;

    // Redo the choice for the outstanding erase to find how far it reached
    frep_choose u_cur (
        .addr      (addr_reg),
        .len       (len_reg),
        .sector_lg (sector_lg),
        .act       (cur_act),
        .base      (cur_base),
        .next_addr (cur_end)
    );

    assign cur_step = cur_end - addr_reg;
    assign adv_len  = (len_reg < cur_step) ? '0 : len_reg - cur_step;

    // Decode a new range
    assign range_bad = item.end_addr < item.start_addr;
    assign new_start = {1'b0, item.start_addr};
    assign new_len   = {1'b0, item.end_addr} - new_start + STATE_W'(1);

    // Choose the erase to issue next
    assign pick_addr = (item.kind == KIND_RANGE) ? new_start : cur_end;
    assign pick_len  = (item.kind == KIND_RANGE) ? new_len   : adv_len;

    frep_choose u_pick (
        .addr      (pick_addr),
        .len       (pick_len),
        .sector_lg (sector_lg),
        .act       (pick_act),
        .base      (pick_base),
        .next_addr (pick_end)
    );

    // Form the result and the next walk state
    always_comb
    begin
        busy_next         = busy_reg;
        addr_next         = addr_reg;
        len_next          = len_reg;
        result.action     = ACT_REJECT;
        result.erase_addr = '0;
        if (item.kind == KIND_RANGE)
        begin
            if (!busy_reg && !range_bad)
            begin
                busy_next         = 1'b1;
                addr_next         = new_start;
                len_next          = new_len;
                result.action     = pick_act;
                result.erase_addr = pick_base[ADDR_BITS-1:0];
            end
        end
        else if (busy_reg)
        begin
            if (!item.erase_ok)
            begin
                busy_next     = 1'b0;
                result.action = ACT_FAIL;
            end
            else
            begin
                addr_next = cur_end;
                len_next  = adv_len;
                if (adv_len == '0)
                begin
                    busy_next     = 1'b0;
                    result.action = ACT_DONE;
                end
                else
                begin
                    result.action     = pick_act;
                    result.erase_addr = pick_base[ADDR_BITS-1:0];
                end
            end
        end
    end

    // Update the walk state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            addr_reg <= '0;
            len_reg  <= '0;
        end
        else if (fire)
        begin
            busy_reg <= busy_next;
            addr_reg <= addr_next;
            len_reg  <= len_next;
        end
    end

    assign status.busy   = busy_reg;
    assign status.issued = (result.action == ACT_SECTOR) || (result.action == ACT_B32)
                        || (result.action == ACT_B64);

    // The end of the chosen erase and the kind of the current one are not needed
    // beyond the choice itself
    logic unused_pick;
    assign unused_pick = ^{pick_end, cur_act, cur_base};

endmodule

/* verif/tb.sv */
// Self-checking testbench for flash_range_erase_planner: directed walks, then random walks
// under three idling patterns, every result checked against a built-in walk predictor.
// Depends on frep_pkg and flash_range_erase_planner.
module tb;
    import frep_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int REPORT_MAX  = 10;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            req_valid;
    logic            req_stall;
    req_t            req;
    logic            rsp_valid;
    logic            rsp_stall;
    rsp_t            rsp;
    logic            cfg_we;
    logic [LG_W-1:0] cfg_wdata;

    // Walk predictor state and its copy of the sector size register
    logic               wk_busy;
    logic [STATE_W-1:0] wk_addr;
    logic [STATE_W-1:0] wk_left;
    logic [LG_W-1:0]    sector_lg;

    rsp_t rsp_due[$];
    int   send_idle_pct;
    int   recv_idle_pct;
    int   req_count;
    int   mismatches;
    int   cycles;

    flash_range_erase_planner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Pick the erase at addr for len bytes: its kind, base and exclusive end
    function automatic void plan_erase(input logic [STATE_W-1:0] addr,
                                       input logic [STATE_W-1:0] len,
                                       output action_t act,
                                       output logic [STATE_W:0] base,
                                       output logic [STATE_W:0] stop);
        logic [LG_W-1:0]  lg;
        logic [STATE_W:0] sec;
        logic [STATE_W:0] b64;
        logic [STATE_W:0] b32;
        lg = (sector_lg < SECTOR_LG_MIN) ? SECTOR_LG_MIN : sector_lg;
        sec = '0;
        sec[lg] = 1'b1;
        b64 = (STATE_W+1)'(BLOCK64_BYTES);
        b32 = (STATE_W+1)'(BLOCK32_BYTES);
        if (addr[B64_LOG2-1:0] == '0 && {1'b0, len} > b64 - sec)
        begin
            act  = ACT_B64;
            base = {1'b0, addr};
            stop = base + b64;
        end
        else if (addr[B32_LOG2-1:0] == '0 && {1'b0, len} > b32 - sec)
        begin
            act  = ACT_B32;
            base = {1'b0, addr};
            stop = base + b32;
        end
        else
        begin
            act  = ACT_SECTOR;
            base = {1'b0, addr} & ~(sec - (STATE_W+1)'(1));
            stop = base + sec;
        end
    endfunction

    // Advance the walk by one request and return the result it must produce
    function automatic rsp_t advance_walk(input req_t r);
        rsp_t             res;
        action_t          act;
        logic [STATE_W:0] base;
        logic [STATE_W:0] stop;
        logic [STATE_W:0] step;
        res.action     = ACT_REJECT;
        res.erase_addr = '0;
        if (r.kind == KIND_RANGE)
        begin
            if (!wk_busy && r.end_addr >= r.start_addr)
            begin
                wk_busy = 1'b1;
                wk_addr = {1'b0, r.start_addr};
                wk_left = {1'b0, r.end_addr} - {1'b0, r.start_addr} + STATE_W'(1);
                plan_erase(wk_addr, wk_left, act, base, stop);
                res.action     = act;
                res.erase_addr = base[ADDR_BITS-1:0];
            end
        end
        else if (wk_busy)
        begin
            if (!r.erase_ok)
            begin
                wk_busy    = 1'b0;
                res.action = ACT_FAIL;
            end
            else
            begin
                // Step past the erase just done, saturating the length at zero
                plan_erase(wk_addr, wk_left, act, base, stop);
                step    = stop - {1'b0, wk_addr};
                wk_left = ({1'b0, wk_left} < step) ? '0 : wk_left - step[STATE_W-1:0];
                wk_addr = stop[STATE_W-1:0];
                if (wk_left == '0)
                begin
                    wk_busy    = 1'b0;
                    res.action = ACT_DONE;
                end
                else
                begin
                    plan_erase(wk_addr, wk_left, act, base, stop);
                    res.action     = act;
                    res.erase_addr = base[ADDR_BITS-1:0];
                end
            end
        end
        return res;
    endfunction

    function automatic req_t make_req(input logic kind, input logic [ADDR_BITS-1:0] s,
                                      input logic [ADDR_BITS-1:0] e, input logic ok);
        req_t r;
        r.kind       = kind;
        r.start_addr = s;
        r.end_addr   = e;
        r.erase_ok   = ok;
        return r;
    endfunction

    // Offer one request, with random idle cycles ahead of it; return once it is taken
    task automatic issue_req(input req_t r);
        logic taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(negedge clk);
            taken = (req_stall === 1'b0);
            if (taken)
            begin
                rsp_due.push_back(advance_walk(r));
                req_count++;
            end
            @(posedge clk);
        end
        while (!taken);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (rsp_due.size() != 0);
    endtask

    task automatic write_sector_lg(input logic [LG_W-1:0] lg);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sector_lg = lg;
        @(posedge clk);
    endtask

    // Stray items, then one well-formed walk with random content and occasional noise
    task automatic random_walk();
        logic [LG_W-1:0]    lg;
        logic [ADDR_BITS:0] s;
        logic [ADDR_BITS:0] e;
        logic [ADDR_BITS:0] mask;
        int unsigned        len;
        int                 pick;
        lg   = (sector_lg < SECTOR_LG_MIN) ? SECTOR_LG_MIN : sector_lg;
        pick = $urandom_range(99);
        if (pick < 10)
            issue_req(make_req(KIND_COMPLETE, 24'($urandom), 24'($urandom), 1'($urandom)));
        else if (pick < 18)
        begin
            s = (ADDR_BITS+1)'($urandom_range(24'hFFFFFF, 1));
            e = (ADDR_BITS+1)'($urandom_range(s - 1, 0));
            issue_req(make_req(KIND_RANGE, s[ADDR_BITS-1:0], e[ADDR_BITS-1:0],
                               1'($urandom)));
        end

        s    = (ADDR_BITS+1)'($urandom_range(24'hFFFFFF));
        pick = $urandom_range(99);
        if (pick < 55)
            len = $urandom_range(4 << lg, 1);
        else if (pick < 75)
        begin
            // Start a few sectors short of a 32K or 64K boundary
            mask = $urandom_range(1) ? 25'h7FFF : 25'hFFFF;
            s    = (s | mask) - ((ADDR_BITS+1)'($urandom_range(3 << lg)) & mask);
            len  = $urandom_range(32'h20000, 1);
        end
        else if (pick < 92)
        begin
            s   = s & ($urandom_range(1) ? ~25'h7FFF : ~25'hFFFF);
            len = $urandom_range(32'h80000, 1);
        end
        else
        begin
            s   = s & ~25'hFFFF;
            len = $urandom_range(32'h400000, 1);
        end
        e = (ADDR_BITS+1)'(s + len - 1);
        if (e > 25'hFFFFFF)
            e = 25'hFFFFFF;
        issue_req(make_req(KIND_RANGE, s[ADDR_BITS-1:0], e[ADDR_BITS-1:0], 1'($urandom)));

        while (wk_busy)
        begin
            pick = $urandom_range(99);
            if (pick < 4)
                issue_req(make_req(KIND_COMPLETE, 24'($urandom), 24'($urandom), 1'b0));
            else if (pick < 8)
                issue_req(make_req(KIND_RANGE, 24'($urandom), 24'($urandom),
                                   1'($urandom)));
            else
                issue_req(make_req(KIND_COMPLETE, 24'($urandom), 24'($urandom), 1'b1));
        end
    endtask

    task automatic test_directed_walks();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        // Two 64K blocks, then done
        issue_req(make_req(KIND_RANGE, 24'h000000, 24'h01FFFF, 1'b0));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        issue_req(make_req(KIND_COMPLETE, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        // Completion while idle, end below start
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        issue_req(make_req(KIND_RANGE, 24'h000010, 24'h00000F, 1'b1));
        issue_req(make_req(KIND_RANGE, 24'hFFFFFF, 24'h000000, 1'b0));
        // Last sector of the device
        issue_req(make_req(KIND_RANGE, 24'hFFF000, 24'hFFFFFF, 1'b1));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        // One 32K block
        issue_req(make_req(KIND_RANGE, 24'h008000, 24'h00FFFF, 1'b0));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        // Request while busy, then a failed erase
        issue_req(make_req(KIND_RANGE, 24'h123456, 24'h200000, 1'b1));
        issue_req(make_req(KIND_RANGE, 24'h000000, 24'hFFFFFF, 1'b1));
        issue_req(make_req(KIND_COMPLETE, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
        // Single-byte ranges at both ends
        issue_req(make_req(KIND_RANGE, 24'h000000, 24'h000000, 1'b0));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        issue_req(make_req(KIND_RANGE, 24'hFFFFFF, 24'hFFFFFF, 1'b1));
        issue_req(make_req(KIND_COMPLETE, 24'hFFFFFF, 24'hFFFFFF, 1'b0));
    endtask

    task automatic test_config_mid_walk();
        // Change the sector size between the first erase and its completion
        issue_req(make_req(KIND_RANGE, 24'h001000, 24'h008FFF, 1'b0));
        write_sector_lg(4'd15);
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
        // Sizes below the minimum act as 256 bytes
        write_sector_lg(4'd0);
        issue_req(make_req(KIND_RANGE, 24'h000180, 24'h0001FF, 1'b0));
        issue_req(make_req(KIND_COMPLETE, 24'h000000, 24'h000000, 1'b1));
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n,
                                     input logic [LG_W-1:0] first_lg);
        int target;
        int next_cfg;
        target        = req_count + n;
        next_cfg      = req_count + 70;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_sector_lg(first_lg);
        while (req_count < target)
        begin
            if (req_count >= next_cfg)
            begin
                write_sector_lg(LG_W'($urandom_range(15)));
                next_cfg = req_count + 70;
            end
            random_walk();
        end
    endtask

    // Random receiver stalls
    always @(posedge clk)
        rsp_stall <= ($urandom_range(99) < recv_idle_pct);

    // Compare each result taken at the coming edge with the oldest expectation
    always
    begin : result_check
        rsp_t want;
        @(negedge clk);
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            if (rsp_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: action %0d addr %h",
                             rsp.action, rsp.erase_addr);
            end
            else
            begin
                want = rsp_due.pop_front();
                if (rsp.action !== want.action || rsp.erase_addr !== want.erase_addr)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("expected action %0d addr %h, got action %0d addr %h",
                                 want.action, want.erase_addr, rsp.action, rsp.erase_addr);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = SECTOR_LG_RESET;
        wk_busy   = 1'b0;
        wk_addr   = '0;
        wk_left   = '0;
        sector_lg = SECTOR_LG_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_walks();
        test_config_mid_walk();
        test_random_phase(30, 45, 210, 4'd8);
        test_random_phase(45, 30, 210, 4'd15);
        test_random_phase(0, 0, 210, 4'd0);

        // Let the pipeline empty, then allow for any stray result
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* files.f */
rtl/core/frep_pkg.sv
rtl/core/frep_choose.sv
rtl/core/frep_walk.sv
rtl/core/flash_range_erase_planner.sv
verif/tb.sv
